@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the block allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`define ASSERT_NEVER(lbl, cond)
`endif
`endif

@@ rtl/ffba_pkg.sv @@
// Types and constants of the first-fit block allocator.
package ffba_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int SCAN_W = $clog2(MAX_BLOCKS);
	localparam int HDR_BYTES = 32;
	localparam int ALIGN_BYTES = 16;
	localparam int MIN_SPLIT_PAYLOAD = 16;
	localparam int OFF_W = 25;
	localparam int NEED_W = 33;
	localparam int ADDR_W = 48;
	localparam int CFG_W = 48;

	localparam logic [OFF_W-1:0] HDR_OFF = OFF_W'(HDR_BYTES);
	localparam logic [NEED_W-1:0] HDR_NEED = NEED_W'(HDR_BYTES);
	localparam logic [NEED_W-1:0] SPLIT_NEED = NEED_W'(HDR_BYTES + MIN_SPLIT_PAYLOAD);
	localparam logic [NEED_W-1:0] ALIGN_MASK = ~NEED_W'(ALIGN_BYTES - 1);
	localparam logic [OFF_W-1:0] ALIGN_MASK_OFF = ~OFF_W'(ALIGN_BYTES - 1);
	localparam logic [OFF_W-1:0] HEAP_BYTES_RST = OFF_W'(1048576);

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_HEAP_BASE  = 1'b0,
		REG_HEAP_BYTES = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ZERO     = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_NOFIT    = 3'd3,
		ST_BADFREE  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_TAKE,
		OP_SPLIT,
		OP_SPLITM,
		OP_REL,
		OP_RELR,
		OP_RELL,
		OP_RELB
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_MUL,
		S_CHK,
		S_SCAN,
		S_LATCH,
		S_APPLY,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             valid;
		logic             free;
		logic [OFF_W-1:0] off;
		logic [OFF_W-1:0] size;
	} entry_t;

	typedef struct packed {
		logic             fnd;
		logic             rf;
		logic             lf;
		logic [OFF_W-1:0] off;
		logic [OFF_W-1:0] size;
	} scan_t;

	typedef struct packed {
		op_t               op;
		cmd_t              cmd;
		logic              latch;
		logic [NEED_W-1:0] need;
		logic [ADDR_W-1:0] target;
	} ctl_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] elem_count;
		logic [31:0] elem_bytes;
		logic [47:0] release_addr;
	} req_t;

	typedef struct packed {
		logic [47:0] user_addr;
		status_t     status;
	} rsp_t;

endpackage

@@ rtl/ffba_cell.sv @@
// One table cell: holds a block entry and passes first-match data to its neighbor.
module ffba_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head,
	input  ffba_pkg::ctl_t  ctl,
	input  ffba_pkg::entry_t left_ent,
	input  ffba_pkg::entry_t right_ent,
	input  ffba_pkg::entry_t right2_ent,
	input  ffba_pkg::scan_t left_scan,
	input  logic            left_sel,
	input  logic            right_sel,
	output ffba_pkg::entry_t ent,
	output ffba_pkg::scan_t scan,
	output logic            sel
);

	ffba_pkg::entry_t ent_q, ent_d;
	ffba_pkg::scan_t scan_q, scan_d;
	logic sel_q, aft_q;
	logic hit;
	logic [ffba_pkg::NEED_W-1:0] split_off, split_size, merge_size;
	logic [ffba_pkg::OFF_W-1:0] relr_size, relb_size;

	always_comb begin
		if (ctl.cmd == ffba_pkg::CMD_FREE) begin
			hit = ent_q.valid && !ent_q.free &&
				({{(ffba_pkg::ADDR_W-ffba_pkg::OFF_W){1'b0}}, ent_q.off} == ctl.target);
		end else begin
			hit = ent_q.valid && ent_q.free &&
				({{(ffba_pkg::NEED_W-ffba_pkg::OFF_W){1'b0}}, ent_q.size} >= ctl.need);
		end
	end

	always_comb begin
		scan_d.fnd = left_scan.fnd | hit;
		if (left_scan.fnd) begin
			scan_d.rf = left_scan.rf;
			scan_d.lf = left_scan.lf;
			scan_d.off = left_scan.off;
			scan_d.size = left_scan.size;
		end else begin
			scan_d.rf = right_ent.valid & right_ent.free;
			scan_d.lf = ~head & left_ent.valid & left_ent.free;
			scan_d.off = ent_q.off;
			scan_d.size = ent_q.size;
		end
	end

	always_comb begin
		split_off = ffba_pkg::NEED_W'(left_ent.off) + ffba_pkg::HDR_NEED + ctl.need;
		split_size = ffba_pkg::NEED_W'(left_ent.size) - ctl.need - ffba_pkg::HDR_NEED;
		merge_size = ffba_pkg::NEED_W'(left_ent.size) + ffba_pkg::NEED_W'(ent_q.size) - ctl.need;
		relr_size = ent_q.size + ffba_pkg::HDR_OFF + right_ent.size;
		relb_size = ent_q.size + ffba_pkg::HDR_OFF + ffba_pkg::HDR_OFF + right_ent.size +
			right2_ent.size;
	end

	always_comb begin
		ent_d = ent_q;
		case (ctl.op)
			ffba_pkg::OP_LOAD: begin
				ent_d = head ? left_ent : '0;
			end
			ffba_pkg::OP_TAKE: begin
				if (sel_q) ent_d.free = 1'b0;
			end
			ffba_pkg::OP_SPLIT: begin
				if (sel_q) begin
					ent_d.free = 1'b0;
					ent_d.size = ctl.need[ffba_pkg::OFF_W-1:0];
				end else if (left_sel) begin
					ent_d.valid = 1'b1;
					ent_d.free = 1'b1;
					ent_d.off = split_off[ffba_pkg::OFF_W-1:0];
					ent_d.size = split_size[ffba_pkg::OFF_W-1:0];
				end else if (aft_q) begin
					ent_d = left_ent;
				end
			end
			ffba_pkg::OP_SPLITM: begin
				if (sel_q) begin
					ent_d.free = 1'b0;
					ent_d.size = ctl.need[ffba_pkg::OFF_W-1:0];
				end else if (left_sel) begin
					ent_d.free = 1'b1;
					ent_d.off = split_off[ffba_pkg::OFF_W-1:0];
					ent_d.size = merge_size[ffba_pkg::OFF_W-1:0];
				end
			end
			ffba_pkg::OP_REL: begin
				if (sel_q) ent_d.free = 1'b1;
			end
			ffba_pkg::OP_RELR: begin
				if (sel_q) begin
					ent_d.free = 1'b1;
					ent_d.size = relr_size;
				end else if (aft_q) begin
					ent_d = right_ent;
				end
			end
			ffba_pkg::OP_RELL: begin
				if (right_sel) begin
					ent_d.size = relr_size;
				end else if (sel_q || aft_q) begin
					ent_d = right_ent;
				end
			end
			ffba_pkg::OP_RELB: begin
				if (right_sel) begin
					ent_d.size = relb_size;
				end else if (sel_q || aft_q) begin
					ent_d = right2_ent;
				end
			end
			default: begin
				ent_d = ent_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
			scan_q <= '0;
			sel_q <= 1'b0;
			aft_q <= 1'b0;
		end else begin
			ent_q <= ent_d;
			scan_q <= scan_d;
			if (ctl.latch) begin
				sel_q <= hit & ~left_scan.fnd;
				aft_q <= left_scan.fnd;
			end
		end
	end

	assign ent = ent_q;
	assign scan = scan_q;
	assign sel = sel_q;

endmodule

@@ rtl/first_fit_block_allocator_unit.sv @@
// Top level of the first-fit block allocator with a chain of table cells.
// An allocate or a non-null free passes the multiply, check, scan, latch and apply states before the
// done strobe; its first-match scan ripples one cell per cycle through all 64 cells. A zero,
// overflowing or null request goes from the check state straight to the done strobe. One command is
// worked at a time, so a new one is taken only once busy falls after the done strobe. No receiver stall.
// After reset, and after each heap_bytes write, busy is high while the table is rebuilt.
`include "assert_macros.svh"

module first_fit_block_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ffba_pkg::req_t                req,
	output logic                          done,
	output ffba_pkg::rsp_t                rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [ffba_pkg::CFG_W-1:0]    cfg_data
);

	ffba_pkg::state_t state_q, state_d;
	ffba_pkg::ctl_t ctl;
	ffba_pkg::req_t req_q;
	ffba_pkg::rsp_t rsp_q;
	ffba_pkg::op_t op_q;
	ffba_pkg::entry_t load_ent;
	ffba_pkg::entry_t ent [ffba_pkg::MAX_BLOCKS];
	ffba_pkg::scan_t scan [ffba_pkg::MAX_BLOCKS];
	ffba_pkg::scan_t last;
	logic sel [ffba_pkg::MAX_BLOCKS];
	logic [63:0] prod_q;
	logic [ffba_pkg::NEED_W-1:0] need_q, need_d;
	logic [ffba_pkg::ADDR_W-1:0] target_q;
	logic [ffba_pkg::ADDR_W-1:0] base_q;
	logic [ffba_pkg::OFF_W-1:0] heap_bytes_q;
	logic [ffba_pkg::CNT_W-1:0] count_q;
	logic [ffba_pkg::SCAN_W-1:0] scan_cnt_q;
	logic load_pend_q;
	logic accept;
	logic split_ok;

	assign cfg_ready = 1'b1;
	assign accept = start & ~busy;
	assign last = scan[ffba_pkg::MAX_BLOCKS-1];

	always_comb begin
		load_ent.valid = heap_bytes_q > ffba_pkg::HDR_OFF;
		load_ent.free = 1'b1;
		load_ent.off = '0;
		load_ent.size = (heap_bytes_q - ffba_pkg::HDR_OFF) & ffba_pkg::ALIGN_MASK_OFF;
	end

	always_comb begin
		need_d = (ffba_pkg::NEED_W'(prod_q[31:0]) + ffba_pkg::NEED_W'(ffba_pkg::ALIGN_BYTES - 1))
			& ffba_pkg::ALIGN_MASK;
		split_ok = (count_q < ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS)) &&
			(ffba_pkg::NEED_W'(last.size) >= need_q + ffba_pkg::SPLIT_NEED);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffba_pkg::S_IDLE: begin
				if (load_pend_q) state_d = ffba_pkg::S_LOAD;
				else if (start) state_d = ffba_pkg::S_MUL;
			end
			ffba_pkg::S_LOAD: state_d = ffba_pkg::S_IDLE;
			ffba_pkg::S_MUL: state_d = ffba_pkg::S_CHK;
			ffba_pkg::S_CHK: begin
				if (req_q.cmd == ffba_pkg::CMD_FREE) begin
					state_d = (req_q.release_addr == '0) ? ffba_pkg::S_DONE : ffba_pkg::S_SCAN;
				end else if (req_q.elem_count == '0 || req_q.elem_bytes == '0 ||
						prod_q[63:32] != '0) begin
					state_d = ffba_pkg::S_DONE;
				end else begin
					state_d = ffba_pkg::S_SCAN;
				end
			end
			ffba_pkg::S_SCAN: begin
				if (scan_cnt_q == ffba_pkg::SCAN_W'(ffba_pkg::MAX_BLOCKS - 1))
					state_d = ffba_pkg::S_LATCH;
			end
			ffba_pkg::S_LATCH: state_d = ffba_pkg::S_APPLY;
			ffba_pkg::S_APPLY: state_d = ffba_pkg::S_DONE;
			ffba_pkg::S_DONE: state_d = ffba_pkg::S_IDLE;
			default: state_d = ffba_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ffba_pkg::S_IDLE) || load_pend_q;
		done = (state_q == ffba_pkg::S_DONE);
		rsp = rsp_q;
		ctl.cmd = req_q.cmd;
		ctl.need = need_q;
		ctl.target = target_q;
		ctl.latch = (state_q == ffba_pkg::S_LATCH);
		unique case (state_q)
			ffba_pkg::S_LOAD: ctl.op = ffba_pkg::OP_LOAD;
			ffba_pkg::S_APPLY: ctl.op = op_q;
			default: ctl.op = ffba_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::S_IDLE;
			load_pend_q <= 1'b1;
			base_q <= '0;
			heap_bytes_q <= ffba_pkg::HEAP_BYTES_RST;
			count_q <= '0;
			scan_cnt_q <= '0;
			op_q <= ffba_pkg::OP_NONE;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ffba_pkg::REG_HEAP_BASE) begin
					base_q <= cfg_data[ffba_pkg::ADDR_W-1:0];
				end else begin
					heap_bytes_q <= cfg_data[ffba_pkg::OFF_W-1:0];
					load_pend_q <= 1'b1;
				end
			end else if (state_q == ffba_pkg::S_LOAD) begin
				load_pend_q <= 1'b0;
			end
			if (state_q == ffba_pkg::S_LOAD) begin
				count_q <= load_ent.valid ? ffba_pkg::CNT_W'(1) : '0;
			end
			if (state_q == ffba_pkg::S_SCAN) scan_cnt_q <= scan_cnt_q + 1'b1;
			else scan_cnt_q <= '0;
			if (state_q == ffba_pkg::S_LATCH) begin
				op_q <= ffba_pkg::OP_NONE;
				if (last.fnd) begin
					if (req_q.cmd == ffba_pkg::CMD_ALLOC) begin
						if (split_ok) begin
							op_q <= last.rf ? ffba_pkg::OP_SPLITM : ffba_pkg::OP_SPLIT;
							if (!last.rf) count_q <= count_q + 1'b1;
						end else begin
							op_q <= ffba_pkg::OP_TAKE;
						end
					end else if (last.lf && last.rf) begin
						op_q <= ffba_pkg::OP_RELB;
						count_q <= count_q - ffba_pkg::CNT_W'(2);
					end else if (last.lf) begin
						op_q <= ffba_pkg::OP_RELL;
						count_q <= count_q - 1'b1;
					end else if (last.rf) begin
						op_q <= ffba_pkg::OP_RELR;
						count_q <= count_q - 1'b1;
					end else begin
						op_q <= ffba_pkg::OP_REL;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) req_q <= req;
		if (state_q == ffba_pkg::S_MUL) begin
			prod_q <= 64'(req_q.elem_count) * 64'(req_q.elem_bytes);
			rsp_q <= '0;
		end
		if (state_q == ffba_pkg::S_CHK) begin
			need_q <= need_d;
			target_q <= req_q.release_addr - base_q - ffba_pkg::ADDR_W'(ffba_pkg::HDR_BYTES);
			if (req_q.cmd == ffba_pkg::CMD_ALLOC) begin
				if (req_q.elem_count == '0 || req_q.elem_bytes == '0)
					rsp_q.status <= ffba_pkg::ST_ZERO;
				else if (prod_q[63:32] != '0)
					rsp_q.status <= ffba_pkg::ST_OVERFLOW;
			end
		end
		if (state_q == ffba_pkg::S_LATCH) begin
			if (!last.fnd) begin
				rsp_q.status <= (req_q.cmd == ffba_pkg::CMD_ALLOC) ?
					ffba_pkg::ST_NOFIT : ffba_pkg::ST_BADFREE;
			end else if (req_q.cmd == ffba_pkg::CMD_ALLOC) begin
				rsp_q.user_addr <= base_q + ffba_pkg::ADDR_W'(last.off) +
					ffba_pkg::ADDR_W'(ffba_pkg::HDR_BYTES);
			end
		end
	end

	for (genvar k = 0; k < ffba_pkg::MAX_BLOCKS; k++) begin : g_cell
		ffba_pkg::entry_t l_e, r_e, r2_e;
		ffba_pkg::scan_t l_s;
		logic l_sel, r_sel;

		if (k == 0) begin : g_lo
			assign l_e = load_ent;
			assign l_s = '0;
			assign l_sel = 1'b0;
		end else begin : g_lm
			assign l_e = ent[k-1];
			assign l_s = scan[k-1];
			assign l_sel = sel[k-1];
		end

		if (k == ffba_pkg::MAX_BLOCKS - 1) begin : g_ro
			assign r_e = '0;
			assign r_sel = 1'b0;
		end else begin : g_rm
			assign r_e = ent[k+1];
			assign r_sel = sel[k+1];
		end

		if (k >= ffba_pkg::MAX_BLOCKS - 2) begin : g_r2o
			assign r2_e = '0;
		end else begin : g_r2m
			assign r2_e = ent[k+2];
		end

		ffba_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.head       (k == 0),
			.ctl        (ctl),
			.left_ent   (l_e),
			.right_ent  (r_e),
			.right2_ent (r2_e),
			.left_scan  (l_s),
			.left_sel   (l_sel),
			.right_sel  (r_sel),
			.ent        (ent[k]),
			.scan       (scan[k]),
			.sel        (sel[k])
		);
	end

	`ASSERT_NEXT(a_done_pulse, done, !done)
	`ASSERT_NEXT(a_accept_busy, accept, busy && !done)
	`ASSERT_NEVER(a_count_range, count_q > ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS))
	`ASSERT_NEXT(a_resize_reload, cfg_valid && cfg_ready && cfg_index, busy)

endmodule
